FILE: rtl/core/thm_pkg.sv
// Shared types and constants for the tape head machine.
`default_nettype none

package thm_pkg;

    localparam int THM_TAPE_DEPTH = 1024;
    localparam int CELL_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int OPCODE_W       = 3;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 16;

    localparam logic [CELL_W-1:0] CELL_MAX = 8'd255;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_PRINT = 3'd2,
        OP_GET   = 3'd3,
        OP_LEFT  = 3'd4,
        OP_RIGHT = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EDGE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_RUN  = 3'b010,
        S_MOVE = 3'b100
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/thm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module thm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tape_head_machine.sv
// Tape head machine: byte tape in RAM with a head register and one result per item.
// Cell operations (inc, dec, print, get, refused moves, unused opcodes) are answered in the cycle after they are taken.
// An accepted move passes through S_MOVE: the result waits for the registered RAM read of the new cell.
// The cell under the head is held in a register, so back-to-back cell operations need no read.
// After reset the block zeroes the middle cell in S_INIT, then accepts items.
// Cells outside the visited span read as zero; a move into a new cell writes it to zero.
`default_nettype none

module tape_head_machine
    import thm_pkg::*;
#(
    parameter int TAPE_DEPTH = THM_TAPE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // opcode[2:0], load_value[10:3], zeros above
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // cell_value[7:0], status[9:8], zeros above
);

    localparam int AW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
    localparam logic [AW-1:0] HEAD_MID  = AW'(TAPE_DEPTH / 2);
    localparam logic [AW-1:0] HEAD_LAST = AW'(TAPE_DEPTH - 1);

    state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [CELL_W-1:0] cur_reg, cur_next;
    logic fresh_reg, fresh_next;
    logic m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_cell_reg, m_cell_next;
    status_t m_status_reg, m_status_next;

    logic          s_fire;
    opcode_t       opcode;
    logic [CELL_W-1:0] load_value;
    logic [AW-1:0] new_head;
    logic          new_fresh;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign opcode     = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign load_value = s_tdata[OPCODE_W +: CELL_W];
    assign s_tready   = (state_reg == S_RUN) && (!m_valid_reg || m_tready);
    assign s_fire     = s_tvalid && s_tready;

    // Opcode bit 0 separates move right from move left.
    assign new_head  = s_tdata[0] ? head_reg + AW'(1) : head_reg - AW'(1);
    assign new_fresh = (new_head < lo_reg) || (new_head > hi_reg);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        cur_next      = cur_reg;
        fresh_next    = fresh_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_cell_next   = m_cell_reg;
        m_status_next = m_status_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = cur_reg;

        unique case (state_reg)
            S_INIT: begin
                ram_we     = 1'b1;
                ram_waddr  = HEAD_MID;
                ram_wdata  = '0;
                state_next = S_RUN;
            end
            S_RUN: begin
                if (s_fire) begin
                    m_valid_next  = 1'b1;
                    m_cell_next   = cur_reg;
                    m_status_next = ST_OK;
                    case (opcode)
                        OP_INC: begin
                            if (cur_reg == CELL_MAX) begin
                                m_status_next = ST_RANGE;
                            end else begin
                                cur_next    = cur_reg + CELL_W'(1);
                                m_cell_next = cur_next;
                                ram_we      = 1'b1;
                                ram_wdata   = cur_next;
                            end
                        end
                        OP_DEC: begin
                            if (cur_reg == '0) begin
                                m_status_next = ST_RANGE;
                            end else begin
                                cur_next    = cur_reg - CELL_W'(1);
                                m_cell_next = cur_next;
                                ram_we      = 1'b1;
                                ram_wdata   = cur_next;
                            end
                        end
                        OP_GET: begin
                            cur_next    = load_value;
                            m_cell_next = load_value;
                            ram_we      = 1'b1;
                            ram_wdata   = load_value;
                        end
                        OP_LEFT, OP_RIGHT: begin
                            if ((opcode == OP_LEFT && head_reg == '0) ||
                                (opcode == OP_RIGHT && head_reg >= HEAD_LAST)) begin
                                m_status_next = ST_EDGE;
                            end else begin
                                // Result waits for the RAM read of the new cell.
                                m_valid_next = 1'b0;
                                head_next    = new_head;
                                fresh_next   = new_fresh;
                                state_next   = S_MOVE;
                                if (new_fresh) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = new_head;
                                    ram_wdata = '0;
                                    if (new_head < lo_reg) begin
                                        lo_next = new_head;
                                    end else begin
                                        hi_next = new_head;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                cur_next      = fresh_reg ? '0 : ram_rdata;
                m_valid_next  = 1'b1;
                m_cell_next   = cur_next;
                m_status_next = ST_OK;
                state_next    = S_RUN;
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            head_reg    <= HEAD_MID;
            lo_reg      <= HEAD_MID;
            hi_reg      <= HEAD_MID;
            cur_reg     <= '0;
            fresh_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            cur_reg     <= cur_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_cell_reg   <= m_cell_next;
        m_status_reg <= m_status_next;
    end

    thm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (new_head),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CELL_W - STATUS_W)'(0), m_status_reg, m_cell_reg};

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the tape head machine: directed and random stream traffic against a tape model.
module tb;
    import thm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPCODE_W-1:0] OP_NOP_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_NOP_B = 3'd7;
    localparam int HEAD_LAST = THM_TAPE_DEPTH - 1;
    localparam int MAX_WAIT  = 17;

    typedef struct packed {
        logic [CELL_W-1:0]   load_value;
        logic [OPCODE_W-1:0] opcode;
    } tape_cmd_t;

    typedef struct packed {
        status_t           status;
        logic [CELL_W-1:0] cell_value;
    } tape_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // opcode[2:0], load_value[10:3], zeros above
    wire                  s_tready;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [M_TDATA_W-1:0] m_tdata;          // cell_value[7:0], status[9:8], zeros above

    tape_head_machine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Model of the tape as seen from outside.
    logic [CELL_W-1:0] tape_model [THM_TAPE_DEPTH];
    int                head_model;

    tape_cmd_t    pending_cmds[$];
    tape_result_t expected_results[$];
    tape_cmd_t    tx_cmd;

    int plan_head = THM_TAPE_DEPTH / 2;
    int tx_gap    = 0;
    int tx_calm   = 0;
    int rx_wait   = 0;
    int rx_calm   = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_range   = 0;
    int n_edge    = 0;
    int n_errors  = 0;

    initial begin
        for (int i = 0; i < THM_TAPE_DEPTH; i++) tape_model[i] = '0;
        head_model = THM_TAPE_DEPTH / 2;
    end

    function automatic tape_result_t apply_command(input tape_cmd_t cmd);
        tape_result_t res;
        res.status = ST_OK;
        case (cmd.opcode)
            OP_INC: begin
                if (tape_model[head_model] == CELL_MAX) res.status = ST_RANGE;
                else tape_model[head_model] = tape_model[head_model] + 8'd1;
            end
            OP_DEC: begin
                if (tape_model[head_model] == '0) res.status = ST_RANGE;
                else tape_model[head_model] = tape_model[head_model] - 8'd1;
            end
            OP_GET: tape_model[head_model] = cmd.load_value;
            OP_LEFT: begin
                if (head_model == 0) res.status = ST_EDGE;
                else head_model--;
            end
            OP_RIGHT: begin
                if (head_model >= HEAD_LAST) res.status = ST_EDGE;
                else head_model++;
            end
            default: ;
        endcase
        res.cell_value = tape_model[head_model];
        return res;
    endfunction

    // Wait lengths come in runs: mostly random, sometimes a stretch of back-to-back items.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void queue_cmd(input logic [OPCODE_W-1:0] op,
                                      input logic [CELL_W-1:0]   val);
        tape_cmd_t cmd;
        cmd.opcode     = op;
        cmd.load_value = val;
        pending_cmds.push_back(cmd);
        if (op == OP_LEFT && plan_head > 0) plan_head--;
        else if (op == OP_RIGHT && plan_head < HEAD_LAST) plan_head++;
    endfunction

    // A positive or negative direction biases the item toward long walks of the head.
    function automatic void queue_random(input int dir);
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [CELL_W-1:0]   val;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       val = 8'd0;
            1:       val = CELL_MAX;
            2:       val = $urandom_range(0, 1) ? 8'd1 : 8'd254;
            default: val = CELL_W'($urandom_range(0, 255));
        endcase
        if (dir != 0 && pick < 88) begin
            if ($urandom_range(0, 99) < 95) op = (dir < 0) ? OP_LEFT : OP_RIGHT;
            else op = (dir < 0) ? OP_RIGHT : OP_LEFT;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 18) op = OP_INC;
            else if (pick < 36) op = OP_DEC;
            else if (pick < 46) op = OP_PRINT;
            else if (pick < 64) op = OP_GET;
            else if (pick < 79) op = OP_LEFT;
            else if (pick < 94) op = OP_RIGHT;
            else if (pick < 97) op = OP_NOP_A;
            else op = OP_NOP_B;
        end
        queue_cmd(op, val);
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Sender: holds each item until taken, then idles for the gap drawn with it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_command(tx_cmd));
                n_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // Item still on the bus.
            end else if (tx_gap != 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                tx_cmd   <= pending_cmds[0];
                s_tdata  <= S_TDATA_W'(pending_cmds[0]);
                s_tvalid <= 1'b1;
                tx_gap   <= pick_wait(tx_calm);
                void'(pending_cmds.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result and stalls for a drawn number of cycles after it.
    always @(posedge aclk) begin
        tape_result_t got;
        tape_result_t want;
        int           w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tvalid && m_tready) begin
            got.cell_value = m_tdata[CELL_W-1:0];
            got.status     = status_t'(m_tdata[CELL_W +: STATUS_W]);
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: result with nothing expected: cell %0d status %0d",
                             $realtime, got.cell_value, got.status);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (got.cell_value !== want.cell_value || got.status !== want.status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: item %0d: want cell %0d st %0d, got cell %0d st %0d",
                                 $realtime, n_checked, want.cell_value, want.status,
                                 got.cell_value, got.status);
                end else if (want.status == ST_RANGE) begin
                    n_range++;
                end else if (want.status == ST_EDGE) begin
                    n_edge++;
                end
            end
            w = pick_wait(rx_calm);
            rx_wait  <= w;
            m_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        // Directed: limits of a cell, every opcode, unused opcodes, moves into fresh cells.
        queue_cmd(OP_PRINT, 8'd0);
        queue_cmd(OP_DEC,   8'd0);
        queue_cmd(OP_INC,   8'hFF);
        queue_cmd(OP_GET,   CELL_MAX);
        queue_cmd(OP_INC,   8'd0);
        queue_cmd(OP_PRINT, 8'hFF);
        queue_cmd(OP_DEC,   8'd0);
        queue_cmd(OP_GET,   8'd0);
        queue_cmd(OP_DEC,   8'hFF);
        queue_cmd(OP_GET,   8'hAA);
        queue_cmd(OP_NOP_A, 8'h55);
        queue_cmd(OP_NOP_B, 8'hFF);
        queue_cmd(OP_RIGHT, 8'd0);
        queue_cmd(OP_PRINT, 8'd0);
        queue_cmd(OP_GET,   8'h55);
        queue_cmd(OP_LEFT,  8'd0);
        queue_cmd(OP_LEFT,  8'd0);
        queue_cmd(OP_RIGHT, 8'd0);
        queue_cmd(OP_RIGHT, 8'd0);
        queue_cmd(OP_INC,   8'd0);
        queue_cmd(OP_GET,   8'd1);
        queue_cmd(OP_DEC,   8'd0);
        queue_cmd(OP_DEC,   8'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // The stimulus waits here until the block has answered every queued item.
        wait_drained();

        for (int i = 0; i < 100; i++) queue_random(0);
        while (plan_head > 0) queue_random(-1);
        for (int i = 0; i < 30; i++) queue_random(-1);
        wait_drained();

        for (int i = 0; i < 100; i++) queue_random(0);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("Sent %0d items, walking the head onto the left end of the tape; checked %0d.",
                 n_sent, n_checked);
        $display("Saw %0d out-of-range refusals and %0d tape-edge refusals; %0d mismatches.",
                 n_range, n_edge, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d items queued and %0d results outstanding.",
                 pending_cmds.size(), expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
